/* src/fp32_to_fp16_clamp_convert_top_assert.svh */
// Assertion macros for the single-to-half converter.
`ifndef FP32_TO_FP16_CLAMP_CONVERT_TOP_ASSERT_SVH
`define FP32_TO_FP16_CLAMP_CONVERT_TOP_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define F2H_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define F2H_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/f2h_pkg.sv */
`default_nettype none
package f2h_pkg;
  localparam int unsigned MagW  = 31;
  localparam int unsigned SglW  = 32;
  localparam int unsigned HalfW = 16;

  localparam logic [MagW-1:0] MinReset    = 31'h33D6BF95;
  localparam logic [MagW-1:0] MaxReset    = 31'h461C4000;
  localparam logic [MagW-1:0] SglInf      = 31'h7F800000;
  localparam logic [MagW-1:0] HalfMinNrm  = 31'h38800000;
  localparam logic [MagW-1:0] HalfMaxNrm  = 31'h477FE000;
  localparam logic [17:0]     Rebias      = 18'h1C000;

  typedef enum logic {
    CFG_MIN_POSITIVE = 1'b0,
    CFG_MAX_FINITE   = 1'b1
  } cfg_idx_e;
endpackage
`default_nettype wire

/* src/fp32_to_fp16_clamp_convert_top.sv */
`default_nettype none
// Channel   | Ports                          | Direction | Handshake
// ----------+--------------------------------+-----------+---------------------------
// input     | start_i, single_bits_i, busy_o | in        | transfer when start & !busy
// result    | done_o, half_bits_o, clamped_o | out       | one-cycle strobe, no stall
// config    | cfg_we_i, cfg_idx_i, cfg_data_i| in        | transfer when cfg_we_i
//
// A new item may transfer every cycle: the input register feeds the clamp and
// conversion logic, whose outcome lands in the result register at the next edge.
// done_o comes from out_vld_q, which follows in_vld_q, which follows the input
// transfer; the result transfers while done_o is high. busy_o is never raised.
// Reset clears the valid flags and loads the threshold registers.
// The receiver cannot stall; results leave on the strobe regardless.
module fp32_to_fp16_clamp_convert_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [f2h_pkg::SglW-1:0]     single_bits_i,
  output logic                              done_o,
  output logic      [f2h_pkg::HalfW-1:0]    half_bits_o,
  output logic                              clamped_o,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [f2h_pkg::MagW-1:0]     cfg_data_i
);
  logic [f2h_pkg::MagW-1:0]  min_q, max_q;
  logic                      in_vld_q, out_vld_q;
  logic [f2h_pkg::SglW-1:0]  in_q;
  logic [f2h_pkg::HalfW-1:0] half_d, half_q;
  logic                      clamp_d, clamp_q;

  assign busy_o = 1'b0;

  // Threshold registers: take a write whenever enabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= f2h_pkg::MinReset;
      max_q <= f2h_pkg::MaxReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        f2h_pkg::CFG_MIN_POSITIVE: min_q <= cfg_data_i;
        f2h_pkg::CFG_MAX_FINITE:   max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the valid flags every cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i;
      out_vld_q <= in_vld_q;
    end
  end

  // Hold payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q <= single_bits_i;
    end
    if (in_vld_q) begin
      half_q  <= half_d;
      clamp_q <= clamp_d;
    end
  end

  f2h_core u_core (
    .single_bits_i (in_q),
    .min_bits_i    (min_q),
    .max_bits_i    (max_q),
    .half_bits_o   (half_d),
    .clamped_o     (clamp_d)
  );

  assign done_o      = out_vld_q;
  assign half_bits_o = half_q;
  assign clamped_o   = clamp_q;

`include "fp32_to_fp16_clamp_convert_top_assert.svh"

  `F2H_ASSERT_NEXT(a_pipe, clk_i, rst_ni, start_i, ##1 done_o, "accepted item lost")
  `F2H_ASSERT_IMP(a_done_src, clk_i, rst_ni, done_o, $past(start_i, 2), "spurious result")
  `F2H_ASSERT_IMP(a_nan_keep, clk_i, rst_ni, in_vld_q && in_q[30:0] > f2h_pkg::SglInf, !clamp_d && half_d[14:9] == 6'b111111, "NaN mishandled")
  `F2H_ASSERT_IMP(a_zero, clk_i, rst_ni, in_vld_q && in_q[30:0] == '0, !clamp_d && half_d[14:0] == '0, "zero altered")
endmodule
`default_nettype wire

/* src/f2h_core.sv */
`default_nettype none
// Clamp a single-precision magnitude and convert to half precision.
module f2h_core (
  input  wire logic [f2h_pkg::SglW-1:0]  single_bits_i,
  input  wire logic [f2h_pkg::MagW-1:0]  min_bits_i,
  input  wire logic [f2h_pkg::MagW-1:0]  max_bits_i,
  output logic      [f2h_pkg::HalfW-1:0] half_bits_o,
  output logic                           clamped_o
);
  logic [f2h_pkg::MagW-1:0] a;
  logic [f2h_pkg::MagW-1:0] v;
  logic                     sgn;
  logic                     xnan;
  logic [7:0]               e;
  logic [23:0]              mant;
  logic [7:0]               sh;
  logic [14:0]              h;
  logic [17:0]              top;

  always_comb begin
    sgn  = single_bits_i[31];
    a    = single_bits_i[30:0];
    xnan = a > f2h_pkg::SglInf;
    v    = a;
    clamped_o = 1'b0;
    if (!xnan && !(min_bits_i > f2h_pkg::SglInf) && a != '0 && a < min_bits_i) begin
      v = min_bits_i;
      clamped_o = 1'b1;
    end else if (!xnan && !(max_bits_i > f2h_pkg::SglInf) && a > max_bits_i) begin
      v = max_bits_i;
      clamped_o = 1'b1;
    end
    // subnormal path
    e    = (v[30:23] == 8'd0) ? 8'd1 : v[30:23];
    mant = {(v[30:23] != 8'd0), v[22:0]};
    sh   = 8'd126 - e;
    top  = v[30:13];
    if (v > f2h_pkg::SglInf) begin
      h = {6'b111111, v[21:13]};
    end else if (v > f2h_pkg::HalfMaxNrm) begin
      h = 15'h7C00;
    end else if (v >= f2h_pkg::HalfMinNrm) begin
      h = 15'(top - f2h_pkg::Rebias);
    end else if (sh >= 8'd24) begin
      h = '0;
    end else begin
      h = 15'(mant >> sh[4:0]);
    end
    half_bits_o = {sgn, h};
  end
endmodule
`default_nettype wire

/* tb/f2h_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module f2h_checker (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     busy_i,
  input  wire logic [f2h_pkg::SglW-1:0] single_bits_i,
  input  wire logic                     done_i,
  input  wire logic [f2h_pkg::HalfW-1:0] half_bits_i,
  input  wire logic                     clamped_i,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic [f2h_pkg::MagW-1:0] cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  typedef struct packed {
    logic [f2h_pkg::HalfW-1:0] half_bits;
    logic                      clamped;
  } half_res_t;

  localparam int unsigned Depth = 8;

  logic [f2h_pkg::MagW-1:0] min_thr, max_thr;
  half_res_t                exp_mem[Depth];
  logic [2:0]               wr_ptr, rd_ptr;
  logic [3:0]               fill;

  function automatic logic [f2h_pkg::HalfW-1:0] narrow_to_half(logic [f2h_pkg::SglW-1:0] x);
    logic [f2h_pkg::MagW-1:0] a;
    logic [f2h_pkg::HalfW-1:0] h;
    logic [23:0] mant;
    int          e, sh;
    a = x[f2h_pkg::MagW-1:0];
    if (a > f2h_pkg::SglInf) h = 16'h7E00 | 16'(a[21:13]);
    else if (a > f2h_pkg::HalfMaxNrm) h = 16'h7C00;
    else if (a >= f2h_pkg::HalfMinNrm) h = 16'(a[30:13] - f2h_pkg::Rebias);
    else begin
      e = int'(a[30:23]);
      mant = {1'b0, a[22:0]};
      if (e == 0) e = 1;
      else mant[23] = 1'b1;
      sh = 126 - e;
      h = (sh >= 32) ? '0 : 16'(mant >> sh);
    end
    return h | {x[31], 15'b0};
  endfunction

  function automatic half_res_t clamp_and_narrow(logic [f2h_pkg::SglW-1:0] x);
    half_res_t r;
    logic [f2h_pkg::MagW-1:0] a;
    logic [f2h_pkg::SglW-1:0] v;
    logic nan_x;
    a = x[f2h_pkg::MagW-1:0];
    nan_x = a > f2h_pkg::SglInf;
    v = x;
    r.clamped = 1'b0;
    // minimum test first; a NaN threshold never matches
    if (!nan_x && !(min_thr > f2h_pkg::SglInf) && a != '0 && a < min_thr) begin
      v = {x[31], min_thr};
      r.clamped = 1'b1;
    end else if (!nan_x && !(max_thr > f2h_pkg::SglInf) && a > max_thr) begin
      v = {x[31], max_thr};
      r.clamped = 1'b1;
    end
    r.half_bits = narrow_to_half(v);
    return r;
  endfunction

  assign pending_o = int'(fill);

  always @(posedge clk_i or negedge rst_ni) begin
    half_res_t exp_r;
    logic      push, pop;
    if (!rst_ni) begin
      min_thr <= f2h_pkg::MinReset;
      max_thr <= f2h_pkg::MaxReset;
      fail_count_o <= 0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      push = start_i && !busy_i;
      pop  = done_i && fill != 4'd0;
      if (cfg_we_i) begin
        if (cfg_idx_i == f2h_pkg::CFG_MIN_POSITIVE) min_thr <= cfg_data_i;
        else max_thr <= cfg_data_i;
      end
      if (push) begin
        exp_mem[wr_ptr] <= clamp_and_narrow(single_bits_i);
        wr_ptr <= wr_ptr + 3'd1;
      end
      if (done_i) begin
        if (!pop) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result %h", half_bits_i);
        end else begin
          exp_r = exp_mem[rd_ptr];
          rd_ptr <= rd_ptr + 3'd1;
          if (exp_r.half_bits !== half_bits_i || exp_r.clamped !== clamped_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("result wrong: expected %h/%b got %h/%b", exp_r.half_bits,
                       exp_r.clamped, half_bits_i, clamped_i);
          end
        end
      end
      if (push && !pop) fill <= fill + 4'd1;
      else if (pop && !push) fill <= fill - 4'd1;
    end
  end
endmodule
`default_nettype wire

/* tb/fp32_to_fp16_clamp_convert_top_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module fp32_to_fp16_clamp_convert_top_tb;
  logic clk_i, rst_ni, start_i, busy_o, done_o, clamped_o;
  logic cfg_we_i, cfg_idx_i;
  logic [f2h_pkg::SglW-1:0]  single_bits_i;
  logic [f2h_pkg::HalfW-1:0] half_bits_o;
  logic [f2h_pkg::MagW-1:0]  cfg_data_i;
  int fail_count, pending, cycle_count;

  fp32_to_fp16_clamp_convert_top dut (.*);

  f2h_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .single_bits_i,
    .done_i(done_o), .half_bits_i(half_bits_o), .clamped_i(clamped_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung run: report a mismatch and stop.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("fp32_to_fp16_clamp_convert_top: mismatch");
      $finish;
    end
  end

  // Hold start until the transfer happens; drop it only if no item follows at once.
  task automatic send_single(logic [f2h_pkg::SglW-1:0] x, bit random_gap);
    int gap;
    gap = random_gap ? $urandom_range(0, 16) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    single_bits_i <= x;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic go_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(f2h_pkg::cfg_idx_e idx, logic [f2h_pkg::MagW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random pattern biased toward the thresholds and the half range edges.
  function automatic logic [f2h_pkg::SglW-1:0] pick_single(logic [f2h_pkg::MagW-1:0] lo,
                                                          logic [f2h_pkg::MagW-1:0] hi);
    logic [f2h_pkg::MagW-1:0] a;
    case ($urandom_range(0, 7))
      0: a = 31'(lo + $urandom_range(0, 4) - 2);
      1: a = 31'(hi + $urandom_range(0, 4) - 2);
      2: a = 31'(f2h_pkg::HalfMaxNrm + $urandom_range(0, 'h4000) - 31'h2000);
      3: a = 31'(f2h_pkg::HalfMinNrm + $urandom_range(0, 'h4000) - 31'h2000);
      4: a = {8'($urandom_range(100, 145)), 23'($urandom)};
      5: a = $urandom_range(0, 3) == 0 ? f2h_pkg::SglInf :
             31'(f2h_pkg::SglInf + $urandom_range(1, 'h7FFFFF));
      default: a = 31'($urandom);
    endcase
    return {1'($urandom), a};
  endfunction

  localparam logic [f2h_pkg::MagW-1:0] SglMaxFin = 31'h7F7FFFFF;
  logic [f2h_pkg::MagW-1:0] lo_set[6] = '{f2h_pkg::MinReset, 31'h0, 31'h1, 31'h7FC00000,
                                          31'h40000000, 31'h7F7FFFFF};
  logic [f2h_pkg::MagW-1:0] hi_set[6] = '{f2h_pkg::MaxReset, SglMaxFin, f2h_pkg::SglInf,
                                          31'h7FFFFFFF, 31'h3F800000, 31'h0};
  logic [f2h_pkg::SglW-1:0] directed[22] = '{
    32'h0, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h477F_E000, 32'h477F_E001,
    32'hC780_0000, 32'h3880_0000, 32'h387F_FFFF, 32'h3300_0000, 32'h3380_0000,
    32'h461C_4000, 32'h461C_4001, 32'h33D6_BF94, 32'hB3D6_BF95, 32'h7F7F_FFFF,
    32'h3F80_0000
  };

  initial begin
    cycle_count = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    single_bits_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_data_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed transfers at the reset thresholds.
    foreach (directed[i]) send_single(directed[i], 1'b0);
    go_idle();

    // Advance through threshold settings, crossed and NaN ones among them.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(f2h_pkg::CFG_MIN_POSITIVE, lo_set[ph]);
      write_reg(f2h_pkg::CFG_MAX_FINITE, hi_set[ph]);
      for (int n = 0; n < 320; n++)
        send_single(pick_single(lo_set[ph], hi_set[ph]), $urandom_range(0, 2) != 0);
      go_idle();
    end

    repeat (5) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("fp32_to_fp16_clamp_convert_top: match");
    end else begin
      $display("fp32_to_fp16_clamp_convert_top: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
